### design/wavp_pkg.sv
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types, codes and tag constants for the WAV header stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wavp_pkg;

	localparam logic [31:0] FMT_MIN = 32'd16;

	typedef enum logic [3:0] {
		PH_RIFF  = 4'd0,
		PH_RSIZE = 4'd1,
		PH_WAVE  = 4'd2,
		PH_FMT   = 4'd3,
		PH_FSIZE = 4'd4,
		PH_FBODY = 4'd5,
		PH_FSKIP = 4'd6,
		PH_CHDR  = 4'd7,
		PH_CSKIP = 4'd8,
		PH_DATA  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_PAY = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TRUNC = 3'd1,
		ST_RIFF  = 3'd2,
		ST_ZERO  = 3'd3,
		ST_WAVE  = 3'd4,
		ST_FMT   = 3'd5,
		ST_SHORT = 3'd6
	} status_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [15:0] audio_format;
		logic [15:0] channel_count;
		logic [31:0] sampling_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] sample_bits;
		logic [7:0]  payload;
		logic        payload_last;
	} res_t;

	// Expected character of a four-letter chunk tag; the data tag serves the
	// chunk header phase.
	function automatic logic [7:0] tag_char(phase_t ph, logic [1:0] idx);
		logic [31:0] tag;
		case (ph)
			PH_RIFF: tag = {8'h46, 8'h46, 8'h49, 8'h52};
			PH_WAVE: tag = {8'h45, 8'h56, 8'h41, 8'h57};
			PH_FMT:  tag = {8'h20, 8'h74, 8'h6D, 8'h66};
			default: tag = {8'h61, 8'h74, 8'h61, 8'h64};
		endcase
		return tag[{idx, 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

### design/wavp_in_if.sv
// ----------------------------------------------------------------------------
// wavp_in_if
// Byte stream channel into the parser: one file byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wavp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_stream;

	modport source (output valid, output byte_in, output end_of_stream, input ready);
	modport sink (input valid, input byte_in, input end_of_stream, output ready);
endinterface

`default_nettype wire

### design/wavp_out_if.sv
// ----------------------------------------------------------------------------
// wavp_out_if
// Result channel of the parser: header, payload byte or error per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wavp_out_if;
	logic              valid;
	logic              ready;
	wavp_pkg::kind_t   kind;
	wavp_pkg::status_t status;
	logic [15:0]       audio_format;
	logic [15:0]       channel_count;
	logic [31:0]       sampling_rate;
	logic [31:0]       byte_rate;
	logic [15:0]       block_align;
	logic [15:0]       sample_bits;
	logic [7:0]        payload;
	logic              payload_last;

	modport source (
		output valid, output kind, output status, output audio_format,
		output channel_count, output sampling_rate, output byte_rate,
		output block_align, output sample_bits, output payload,
		output payload_last, input ready
	);
	modport sink (
		input valid, input kind, input status, input audio_format,
		input channel_count, input sampling_rate, input byte_rate,
		input block_align, input sample_bits, input payload,
		input payload_last, output ready
	);
endinterface

`default_nettype wire

### design/wav_header_stream_parser_unit.sv
// A transferred byte waits in the input register until the parser steps on it,
// which loads the result register; the sink then takes the result from it.
// Throughput: one byte per cycle unless the sink stalls; one parse step per byte.
// A byte with no result (tags, sizes, skipped chunks) also takes a parse step.
// Reset (arst_n low, asynchronous): both register stages empty, parser back
// to expecting the RIFF tag with all captured fields cleared.
// ----------------------------------------------------------------------------
// wav_header_stream_parser_unit
// WAV header parser: checks RIFF/WAVE/fmt, captures the format fields, skips
// chunks up to the data chunk and then passes data bytes through.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_stream_parser_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	wavp_in_if.sink   stream,
	wavp_out_if.source result
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           eos_s1;
	logic           valid_s2;
	wavp_pkg::res_t res_s2;
	wavp_pkg::res_t res;
	logic           res_valid;
	logic           advance;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.byte_in;
			eos_s1  <= stream.end_of_stream;
		end
	end

	wavp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.byte_in       (byte_s1),
		.end_of_stream (eos_s1),
		.res           (res),
		.res_valid     (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid         = valid_s2;
	assign result.kind          = res_s2.kind;
	assign result.status        = res_s2.status;
	assign result.audio_format  = res_s2.audio_format;
	assign result.channel_count = res_s2.channel_count;
	assign result.sampling_rate = res_s2.sampling_rate;
	assign result.byte_rate     = res_s2.byte_rate;
	assign result.block_align   = res_s2.block_align;
	assign result.sample_bits   = res_s2.sample_bits;
	assign result.payload       = res_s2.payload;
	assign result.payload_last  = res_s2.payload_last;

`ifndef NO_ASSERTIONS
	// An error result carries nothing but its status.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == wavp_pkg::KIND_ERR) |->
		(res_s2.audio_format == 16'd0 && res_s2.sampling_rate == 32'd0
		&& res_s2.payload == 8'd0 && !res_s2.payload_last))
		else $error("error result with nonzero fields");

	// A payload result never carries a status or header fields.
	a_pay_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == wavp_pkg::KIND_PAY) |->
		(res_s2.status == wavp_pkg::ST_OK && res_s2.channel_count == 16'd0
		&& res_s2.byte_rate == 32'd0))
		else $error("payload result with header fields");

	// The input stalls only when both stages are full and the sink stalls.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled without a full pipeline");

	// A parse step loads the result register with exactly the step's result.
	a_step_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_s2 == $past(res_valid)))
		else $error("result register out of step with parser");
`endif

endmodule

`default_nettype wire

### design/wavp_parser.sv
// ----------------------------------------------------------------------------
// wavp_parser
// Parse state machine: consumes one byte per step and forms at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module wavp_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     byte_in,
	input  wire logic           end_of_stream,
	output wavp_pkg::res_t      res,
	output logic                res_valid
);

	wavp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  byte_index_q, byte_index_d;
	logic [31:0] word_shift_q, word_shift_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] fmt_size_q, fmt_size_d;
	logic [15:0] format_q, format_d;
	logic [15:0] channels_q, channels_d;
	logic [31:0] rate_q, rate_d;
	logic [31:0] byterate_q, byterate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;
	logic        tag_match_q, tag_match_d;

	logic              err;
	wavp_pkg::status_t err_code;
	logic              bad_phase;
	logic              tag_eq;
	logic              tag_upd;
	logic              last4;
	logic              hdr_hit;
	logic [31:0]       ws_shift;
	logic [31:0]       fmt_rest;
	logic [31:0]       skip_dec;
	logic              clr;

	assign tag_eq   = (byte_in == wavp_pkg::tag_char(phase_q, byte_index_q[1:0]));
	assign tag_upd  = (byte_index_q[1:0] == 2'd0) ? tag_eq : (tag_match_q && tag_eq);
	assign last4    = (byte_index_q == 4'd3);
	assign ws_shift = {byte_in, word_shift_q[31:8]};
	assign fmt_rest = fmt_size_q - wavp_pkg::FMT_MIN;
	assign skip_dec = skip_q - 32'd1;
	assign hdr_hit  = (phase_q == wavp_pkg::PH_CHDR) && (byte_index_q[2:0] == 3'd7)
		&& tag_match_q;

	always_comb begin
		phase_d      = phase_q;
		byte_index_d = byte_index_q;
		word_shift_d = word_shift_q;
		skip_d       = skip_q;
		fmt_size_d   = fmt_size_q;
		format_d     = format_q;
		channels_d   = channels_q;
		rate_d       = rate_q;
		byterate_d   = byterate_q;
		align_d      = align_q;
		bits_d       = bits_q;
		tag_match_d  = tag_match_q;
		err          = 1'b0;
		err_code     = wavp_pkg::ST_OK;
		bad_phase    = 1'b0;
		unique case (phase_q) inside
			wavp_pkg::PH_RIFF, wavp_pkg::PH_WAVE, wavp_pkg::PH_FMT: begin
				tag_match_d = tag_upd;
				if (last4) begin
					if (!tag_upd) begin
						err = 1'b1;
						if (phase_q == wavp_pkg::PH_RIFF) begin
							err_code = wavp_pkg::ST_RIFF;
						end else if (phase_q == wavp_pkg::PH_WAVE) begin
							err_code = wavp_pkg::ST_WAVE;
						end else begin
							err_code = wavp_pkg::ST_FMT;
						end
					end else begin
						byte_index_d = 4'd0;
						if (phase_q == wavp_pkg::PH_RIFF) begin
							phase_d = wavp_pkg::PH_RSIZE;
						end else if (phase_q == wavp_pkg::PH_WAVE) begin
							phase_d = wavp_pkg::PH_FMT;
						end else begin
							phase_d = wavp_pkg::PH_FSIZE;
						end
					end
				end else begin
					byte_index_d = byte_index_q + 4'd1;
				end
			end
			wavp_pkg::PH_RSIZE, wavp_pkg::PH_FSIZE: begin
				word_shift_d = ws_shift;
				if (last4) begin
					byte_index_d = 4'd0;
					if (phase_q == wavp_pkg::PH_RSIZE) begin
						if (ws_shift == 32'd0) begin
							err      = 1'b1;
							err_code = wavp_pkg::ST_ZERO;
						end else begin
							phase_d = wavp_pkg::PH_WAVE;
						end
					end else if (ws_shift < wavp_pkg::FMT_MIN) begin
						err      = 1'b1;
						err_code = wavp_pkg::ST_SHORT;
					end else begin
						fmt_size_d = ws_shift;
						phase_d    = wavp_pkg::PH_FBODY;
					end
				end else begin
					byte_index_d = byte_index_q + 4'd1;
				end
			end
			wavp_pkg::PH_FBODY: begin
				if (byte_index_q < 4'd2) begin
					format_d = {byte_in, format_q[15:8]};
				end else if (byte_index_q < 4'd4) begin
					channels_d = {byte_in, channels_q[15:8]};
				end else if (byte_index_q < 4'd8) begin
					rate_d = {byte_in, rate_q[31:8]};
				end else if (byte_index_q < 4'd12) begin
					byterate_d = {byte_in, byterate_q[31:8]};
				end else if (byte_index_q < 4'd14) begin
					align_d = {byte_in, align_q[15:8]};
				end else begin
					bits_d = {byte_in, bits_q[15:8]};
				end
				if (byte_index_q == 4'd15) begin
					byte_index_d = 4'd0;
					skip_d       = fmt_rest;
					phase_d      = (fmt_rest != 32'd0) ? wavp_pkg::PH_FSKIP : wavp_pkg::PH_CHDR;
				end else begin
					byte_index_d = byte_index_q + 4'd1;
				end
			end
			wavp_pkg::PH_FSKIP, wavp_pkg::PH_CSKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					phase_d      = wavp_pkg::PH_CHDR;
					byte_index_d = 4'd0;
				end
			end
			wavp_pkg::PH_CHDR: begin
				if (!byte_index_q[2]) begin
					tag_match_d = tag_upd;
				end else begin
					word_shift_d = ws_shift;
				end
				if (byte_index_q[2:0] == 3'd7) begin
					byte_index_d = 4'd0;
					if (tag_match_q) begin
						phase_d = wavp_pkg::PH_DATA;
					end else begin
						skip_d  = ws_shift;
						phase_d = (ws_shift != 32'd0) ? wavp_pkg::PH_CSKIP : wavp_pkg::PH_CHDR;
					end
				end else begin
					byte_index_d = {1'b0, byte_index_q[2:0] + 3'd1};
				end
			end
			wavp_pkg::PH_DATA: begin
				phase_d = wavp_pkg::PH_DATA;
			end
			default: begin
				bad_phase = 1'b1;
			end
		endcase
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (bad_phase) begin
			res_valid = 1'b0;
		end else if (err) begin
			res_valid  = 1'b1;
			res.kind   = wavp_pkg::KIND_ERR;
			res.status = err_code;
		end else if (hdr_hit) begin
			res_valid         = 1'b1;
			res.kind          = wavp_pkg::KIND_HDR;
			res.status        = wavp_pkg::ST_OK;
			res.audio_format  = format_q;
			res.channel_count = channels_q;
			res.sampling_rate = rate_q;
			res.byte_rate     = byterate_q;
			res.block_align   = align_q;
			res.sample_bits   = bits_q;
		end else if (phase_q == wavp_pkg::PH_DATA) begin
			res_valid        = 1'b1;
			res.kind         = wavp_pkg::KIND_PAY;
			res.payload      = byte_in;
			res.payload_last = end_of_stream;
		end else if (end_of_stream) begin
			res_valid  = 1'b1;
			res.kind   = wavp_pkg::KIND_ERR;
			res.status = wavp_pkg::ST_TRUNC;
		end
	end

	assign clr = bad_phase || err || end_of_stream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= wavp_pkg::PH_RIFF;
			byte_index_q <= '0;
			word_shift_q <= '0;
			skip_q       <= '0;
			fmt_size_q   <= '0;
			format_q     <= '0;
			channels_q   <= '0;
			rate_q       <= '0;
			byterate_q   <= '0;
			align_q      <= '0;
			bits_q       <= '0;
			tag_match_q  <= 1'b0;
		end else if (step) begin
			if (clr) begin
				phase_q      <= wavp_pkg::PH_RIFF;
				byte_index_q <= '0;
				word_shift_q <= '0;
				skip_q       <= '0;
				fmt_size_q   <= '0;
				format_q     <= '0;
				channels_q   <= '0;
				rate_q       <= '0;
				byterate_q   <= '0;
				align_q      <= '0;
				bits_q       <= '0;
				tag_match_q  <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				byte_index_q <= byte_index_d;
				word_shift_q <= word_shift_d;
				skip_q       <= skip_d;
				fmt_size_q   <= fmt_size_d;
				format_q     <= format_d;
				channels_q   <= channels_d;
				rate_q       <= rate_d;
				byterate_q   <= byterate_d;
				align_q      <= align_d;
				bits_q       <= bits_d;
				tag_match_q  <= tag_match_d;
			end
		end
	end

endmodule

`default_nettype wire

### dv/wav_header_stream_parser_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_header_stream_parser_unit_test
// Self-checking bench for the WAV header parser. It feeds well-formed files
// with random, all-zero or all-ones format fields, extra chunks and payload. It also feeds cut,
// corrupted and noise streams. A cycle-free model of the parser predicts
// every header, payload and error result, and each result is compared field
// by field under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

module wav_header_stream_parser_unit_test;

	localparam int          TOTAL_BYTES  = 1450;
	localparam int          QUIET_LIMIT  = 2000;
	localparam int          DRAIN_CYCLES = 10;
	localparam logic [31:0] TAG_RIFF     = "RIFF";
	localparam logic [31:0] TAG_WAVE     = "WAVE";
	localparam logic [31:0] TAG_FMT      = "fmt ";
	localparam logic [31:0] TAG_DATA     = "data";

	typedef enum int {
		FIELDS_RANDOM,
		FIELDS_LOW,
		FIELDS_HIGH
	} fill_t;

	typedef struct {
		logic [7:0] value;
		logic       is_last;
		logic       drain_first;
	} file_byte_t;

	logic clk;
	logic arst_n;

	wavp_in_if  byte_ch ();
	wavp_out_if res_ch ();

	wav_header_stream_parser_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.result (res_ch)
	);

	file_byte_t     file_bytes[$];
	wavp_pkg::res_t predicted_results[$];
	logic [7:0]     wav_image[$];
	int         error_count;
	int         quiet_cycles;
	int         bytes_sent;
	int         headers_seen;
	int         payload_seen;
	int         errors_seen;
	logic [7:0] status_seen = '0;
	int         burst_left;
	int         gap_left;
	logic [15:0] stall_map;
	int         stall_pos;

	wavp_pkg::phase_t prs_phase;
	logic [3:0]  prs_idx;
	logic [31:0] prs_word;
	logic [31:0] prs_skip;
	logic [31:0] prs_fmt_size;
	logic [15:0] prs_format;
	logic [15:0] prs_chans;
	logic [31:0] prs_rate;
	logic [31:0] prs_brate;
	logic [15:0] prs_align;
	logic [15:0] prs_bits;
	logic        prs_tag_ok;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic reset_parser();
		prs_phase    = wavp_pkg::PH_RIFF;
		prs_idx      = '0;
		prs_word     = '0;
		prs_skip     = '0;
		prs_fmt_size = '0;
		prs_format   = '0;
		prs_chans    = '0;
		prs_rate     = '0;
		prs_brate    = '0;
		prs_align    = '0;
		prs_bits     = '0;
		prs_tag_ok   = 1'b0;
	endtask

	function automatic logic tag_step(input logic [31:0] tag, input logic [7:0] b);
		logic [1:0] pos;
		logic       hit;
		pos = prs_idx[1:0];
		hit = (b == tag[8 * (3 - pos) +: 8]);
		return (pos == 2'd0) ? hit : (prs_tag_ok && hit);
	endfunction

	task automatic parse_file_byte(input logic [7:0] b, input logic eos);
		wavp_pkg::res_t    r;
		logic              emit;
		logic              fail;
		wavp_pkg::status_t code;
		logic              last4;
		logic [3:0]        i;
		r     = '0;
		emit  = 1'b0;
		fail  = 1'b0;
		code  = wavp_pkg::ST_OK;
		last4 = (prs_idx == 4'd3);
		case (prs_phase) inside
			wavp_pkg::PH_RIFF, wavp_pkg::PH_WAVE, wavp_pkg::PH_FMT: begin
				prs_tag_ok = tag_step((prs_phase == wavp_pkg::PH_RIFF) ? TAG_RIFF :
					(prs_phase == wavp_pkg::PH_WAVE) ? TAG_WAVE : TAG_FMT, b);
				if (last4) begin
					if (!prs_tag_ok) begin
						fail = 1'b1;
						code = (prs_phase == wavp_pkg::PH_RIFF) ? wavp_pkg::ST_RIFF :
							(prs_phase == wavp_pkg::PH_WAVE) ? wavp_pkg::ST_WAVE :
							wavp_pkg::ST_FMT;
					end else begin
						prs_phase = (prs_phase == wavp_pkg::PH_RIFF) ? wavp_pkg::PH_RSIZE :
							(prs_phase == wavp_pkg::PH_WAVE) ? wavp_pkg::PH_FMT :
							wavp_pkg::PH_FSIZE;
						prs_idx = '0;
					end
				end else begin
					prs_idx++;
				end
			end
			wavp_pkg::PH_RSIZE, wavp_pkg::PH_FSIZE: begin
				prs_word = {b, prs_word[31:8]};
				if (last4) begin
					prs_idx = '0;
					if (prs_phase == wavp_pkg::PH_RSIZE) begin
						if (prs_word == '0) begin
							fail = 1'b1;
							code = wavp_pkg::ST_ZERO;
						end else begin
							prs_phase = wavp_pkg::PH_WAVE;
						end
					end else if (prs_word < wavp_pkg::FMT_MIN) begin
						fail = 1'b1;
						code = wavp_pkg::ST_SHORT;
					end else begin
						prs_fmt_size = prs_word;
						prs_phase = wavp_pkg::PH_FBODY;
					end
				end else begin
					prs_idx++;
				end
			end
			wavp_pkg::PH_FBODY: begin
				i = prs_idx;
				if (i < 2) prs_format = {b, prs_format[15:8]};
				else if (i < 4) prs_chans = {b, prs_chans[15:8]};
				else if (i < 8) prs_rate = {b, prs_rate[31:8]};
				else if (i < 12) prs_brate = {b, prs_brate[31:8]};
				else if (i < 14) prs_align = {b, prs_align[15:8]};
				else prs_bits = {b, prs_bits[15:8]};
				if (i == 4'd15) begin
					prs_idx = '0;
					prs_skip = prs_fmt_size - wavp_pkg::FMT_MIN;
					prs_phase = (prs_skip != '0) ? wavp_pkg::PH_FSKIP : wavp_pkg::PH_CHDR;
				end else begin
					prs_idx = i + 4'd1;
				end
			end
			wavp_pkg::PH_FSKIP, wavp_pkg::PH_CSKIP: begin
				prs_skip--;
				if (prs_skip == '0) begin
					prs_phase = wavp_pkg::PH_CHDR;
					prs_idx = '0;
				end
			end
			wavp_pkg::PH_CHDR: begin
				i = {1'b0, prs_idx[2:0]};
				if (i < 4) prs_tag_ok = tag_step(TAG_DATA, b);
				else prs_word = {b, prs_word[31:8]};
				if (i == 4'd7) begin
					prs_idx = '0;
					if (prs_tag_ok) begin
						r.kind          = wavp_pkg::KIND_HDR;
						r.status        = wavp_pkg::ST_OK;
						r.audio_format  = prs_format;
						r.channel_count = prs_chans;
						r.sampling_rate = prs_rate;
						r.byte_rate     = prs_brate;
						r.block_align   = prs_align;
						r.sample_bits   = prs_bits;
						emit = 1'b1;
						prs_phase = wavp_pkg::PH_DATA;
					end else begin
						prs_skip = prs_word;
						prs_phase = (prs_skip != '0) ? wavp_pkg::PH_CSKIP : wavp_pkg::PH_CHDR;
					end
				end else begin
					prs_idx = i + 4'd1;
				end
			end
			wavp_pkg::PH_DATA: begin
				r.kind         = wavp_pkg::KIND_PAY;
				r.payload      = b;
				r.payload_last = eos;
				emit = 1'b1;
			end
			default: begin
				reset_parser();
				return;
			end
		endcase
		if (fail) begin
			r = '0;
			r.kind = wavp_pkg::KIND_ERR;
			r.status = code;
			emit = 1'b1;
		end else if (!emit && eos) begin
			r.kind = wavp_pkg::KIND_ERR;
			r.status = wavp_pkg::ST_TRUNC;
			emit = 1'b1;
			fail = 1'b1;
		end
		if (fail || eos) reset_parser();
		if (emit) predicted_results.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	function automatic logic [31:0] field_value(input fill_t mode);
		case (mode)
			FIELDS_LOW: return '0;
			FIELDS_HIGH: return '1;
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic put_le(input logic [31:0] v, input int n);
		int k;
		for (k = 0; k < n; k++) wav_image.push_back(v[8 * k +: 8]);
	endtask

	task automatic put_tag(input logic [31:0] tag);
		int k;
		for (k = 0; k < 4; k++) wav_image.push_back(tag[8 * (3 - k) +: 8]);
	endtask

	task automatic build_wav(input logic [31:0] fmt_len, input int chunks,
		input int pay_len, input fill_t mode);
		logic [31:0] riff_len;
		logic [31:0] junk_tag;
		logic [31:0] junk_len;
		int          k;
		int          n;
		wav_image.delete();
		riff_len = (mode == FIELDS_LOW) ? 32'd1 : (mode == FIELDS_HIGH) ? '1 :
			($urandom % 4000) + 1;
		put_tag(TAG_RIFF);
		put_le(riff_len, 4);
		put_tag(TAG_WAVE);
		put_tag(TAG_FMT);
		put_le(fmt_len, 4);
		put_le(field_value(mode), 2);
		put_le(field_value(mode), 2);
		put_le(field_value(mode), 4);
		put_le(field_value(mode), 4);
		put_le(field_value(mode), 2);
		put_le(field_value(mode), 2);
		repeat (fmt_len - wavp_pkg::FMT_MIN) wav_image.push_back(8'($urandom));
		for (n = 0; n < chunks; n++) begin
			junk_tag = $urandom;
			if ($urandom_range(0, 1) == 1) begin
				// A tag that differs from the data tag in a single letter.
				junk_tag = TAG_DATA;
				k = $urandom_range(0, 3);
				junk_tag[8 * k +: 8] ^= 8'($urandom_range(1, 255));
			end else if (junk_tag == TAG_DATA) begin
				junk_tag[0] = ~junk_tag[0];
			end
			junk_len = $urandom_range(0, 9);
			put_tag(junk_tag);
			put_le(junk_len, 4);
			repeat (junk_len) wav_image.push_back(8'($urandom));
		end
		put_tag(TAG_DATA);
		put_le(field_value(mode), 4);
		repeat (pay_len) wav_image.push_back(8'($urandom));
	endtask

	task automatic queue_image(input int cut, input bit eos_last, input bit drain_first);
		file_byte_t fb;
		int         k;
		for (k = 0; k < cut; k++) begin
			fb.value       = wav_image[k];
			fb.is_last     = eos_last && (k == cut - 1);
			fb.drain_first = drain_first && (k == 0);
			file_bytes.push_back(fb);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : byte_source
		logic offer;
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.byte_in <= '0;
			byte_ch.end_of_stream <= 1'b0;
			reset_parser();
			burst_left = 1;
			gap_left = 0;
		end else begin
			offer = byte_ch.valid;
			if (byte_ch.valid && byte_ch.ready) begin
				parse_file_byte(byte_ch.byte_in, byte_ch.end_of_stream);
				void'(file_bytes.pop_front());
				bytes_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (file_bytes.size() != 0 &&
					!(file_bytes[0].drain_first && predicted_results.size() != 0)) begin
					offer = 1'b1;
					byte_ch.byte_in <= file_bytes[0].value;
					byte_ch.end_of_stream <= file_bytes[0].is_last;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			byte_ch.valid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_sink
		wavp_pkg::res_t seen;
		wavp_pkg::res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_map = '0;
			stall_pos = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				seen.kind          = res_ch.kind;
				seen.status        = res_ch.status;
				seen.audio_format  = res_ch.audio_format;
				seen.channel_count = res_ch.channel_count;
				seen.sampling_rate = res_ch.sampling_rate;
				seen.byte_rate     = res_ch.byte_rate;
				seen.block_align   = res_ch.block_align;
				seen.sample_bits   = res_ch.sample_bits;
				seen.payload       = res_ch.payload;
				seen.payload_last  = res_ch.payload_last;
				case (seen.kind)
					wavp_pkg::KIND_HDR: headers_seen++;
					wavp_pkg::KIND_PAY: payload_seen++;
					default: begin
						errors_seen++;
						status_seen[seen.status] = 1'b1;
					end
				endcase
				if (predicted_results.size() == 0) begin
					$error("Result of kind %0d arrived with no prediction waiting.", seen.kind);
					error_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(seen.kind));
					check_field("status", 32'(want.status), 32'(seen.status));
					check_field("audio_format", 32'(want.audio_format),
						32'(seen.audio_format));
					check_field("channel_count", 32'(want.channel_count),
						32'(seen.channel_count));
					check_field("sampling_rate", want.sampling_rate, seen.sampling_rate);
					check_field("byte_rate", want.byte_rate, seen.byte_rate);
					check_field("block_align", 32'(want.block_align), 32'(seen.block_align));
					check_field("sample_bits", 32'(want.sample_bits), 32'(seen.sample_bits));
					check_field("payload", 32'(want.payload), 32'(seen.payload));
					check_field("payload_last", 32'(want.payload_last),
						32'(seen.payload_last));
				end
			end
			if (stall_pos == 0) begin
				case ($urandom_range(0, 3))
					0: stall_map = '0;
					1: stall_map = 16'($urandom) & 16'($urandom);
					default: stall_map = 16'($urandom);
				endcase
			end
			res_ch.ready <= !stall_map[stall_pos];
			stall_pos = (stall_pos + 1) % 16;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int    k;
		int    pick;
		bit    hold;
		fill_t mode;
		arst_n <= 1'b0;

		build_wav(16, 0, 4, FIELDS_LOW);
		queue_image(wav_image.size(), 1, 0);
		build_wav(16, 0, 4, FIELDS_HIGH);
		queue_image(wav_image.size(), 1, 0);
		build_wav(17, 1, 3, FIELDS_RANDOM);
		queue_image(wav_image.size(), 1, 1);
		build_wav(18, 3, 0, FIELDS_RANDOM);
		queue_image(wav_image.size(), 1, 0);
		build_wav(16, 2, 6, FIELDS_RANDOM);
		queue_image(wav_image.size(), 1, 0);
		queue_image(1, 1, 0);
		build_wav(16, 1, 0, FIELDS_RANDOM);
		queue_image(wav_image.size() - 1, 1, 0);
		build_wav(16, 0, 2, FIELDS_RANDOM);
		wav_image[3] = 8'h58;
		queue_image(4, 0, 0);
		build_wav(16, 0, 2, FIELDS_RANDOM);
		for (k = 4; k < 8; k++) wav_image[k] = 8'h00;
		queue_image(8, 0, 0);
		build_wav(16, 0, 2, FIELDS_RANDOM);
		wav_image[11] ^= 8'h01;
		queue_image(12, 1, 0);
		build_wav(16, 0, 2, FIELDS_RANDOM);
		wav_image[12] ^= 8'h80;
		queue_image(16, 0, 0);
		build_wav(16, 0, 2, FIELDS_RANDOM);
		wav_image[16] = 8'd15;
		queue_image(20, 1, 0);
		build_wav(16, 0, 0, FIELDS_RANDOM);
		for (k = 16; k < 20; k++) wav_image[k] = 8'hFF;
		queue_image(40, 1, 0);
		build_wav(16, 1, 0, FIELDS_RANDOM);
		for (k = 40; k < 44; k++) wav_image[k] = 8'hFF;
		queue_image(48, 1, 0);

		while (file_bytes.size() < TOTAL_BYTES) begin
			mode = FIELDS_RANDOM;
			if ($urandom_range(0, 7) == 0)
				mode = ($urandom_range(0, 1) == 1) ? FIELDS_LOW : FIELDS_HIGH;
			build_wav(($urandom_range(0, 2) == 0) ? 32'(16 + $urandom_range(0, 8)) : 32'd16,
				$urandom_range(0, 2), $urandom_range(0, 10), mode);
			pick = $urandom_range(0, 99);
			hold = ($urandom_range(0, 15) == 0);
			if (pick < 60) begin
				queue_image(wav_image.size(), 1, hold);
			end else if (pick < 75) begin
				queue_image($urandom_range(1, wav_image.size()), 1, hold);
			end else if (pick < 90) begin
				k = $urandom_range(0, wav_image.size() - 1);
				wav_image[k] ^= 8'($urandom_range(1, 255));
				queue_image(wav_image.size(), 1, hold);
			end else begin
				wav_image.delete();
				repeat ($urandom_range(1, 12)) wav_image.push_back(8'($urandom));
				queue_image(wav_image.size(), 1, hold);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while ((file_bytes.size() != 0 || predicted_results.size() != 0) &&
			quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("No transfer for %0d cycles with %0d bytes still to send.",
				quiet_cycles, file_bytes.size());
			error_count++;
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
		if (predicted_results.size() != 0) begin
			$error("%0d predicted results never arrived.", predicted_results.size());
			error_count++;
		end

		$display("Sent %0d stream bytes; checked %0d header, %0d payload and %0d error results.",
			bytes_sent, headers_seen, payload_seen, errors_seen);
		$display("Error status codes observed, one bit per code: %b", status_seen);
		if (error_count == 0) begin
			$display("** wav_header_stream_parser_unit: PASSED **");
		end else begin
			$display("** wav_header_stream_parser_unit: FAILED **");
		end
		$finish;
	end

endmodule
